>>> rtl/rbst_pkg.sv
// Shared constants and types for the ray/box slab test pipeline.
`timescale 1ns / 1ps
package rbst_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_AXES   = 3;
    localparam int NUM_FIELDS = 12;
    localparam int EPS_BITS   = 17;
    localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(7);

    localparam int MAG_BITS   = COORD_BITS - 1;
    localparam int QUOT_BITS  = 2 * FRAC_BITS + 1;
    localparam int SPLIT_BITS = FRAC_BITS;
    localparam int HIGH_BITS  = COORD_BITS - SPLIT_BITS;
    localparam int PROD_BITS  = SPLIT_BITS + MAG_BITS;
    localparam int SUM_BITS   = HIGH_BITS + MAG_BITS + 1;

    localparam int S_TDATA_BITS = NUM_FIELDS * COORD_BITS;
    localparam int M_TDATA_BITS = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0] umag_t;
    typedef logic [MAG_BITS-1:0] mag_t;

    localparam mag_t MAX_MAG = {MAG_BITS{1'b1}};

    typedef struct packed {
        logic neg;
        mag_t mag;
    } inv_t;

    typedef struct packed {
        coord_t [NUM_AXES-1:0] origin;
        coord_t [NUM_AXES-1:0] low;
        coord_t [NUM_AXES-1:0] high;
    } geom_t;

    typedef struct packed {
        geom_t                 geom;
        inv_t [NUM_AXES-1:0]   inv;
    } recip_out_t;

endpackage

>>> rtl/ray_box_slab_test_core.sv
// Top level of the ray/axis-aligned box slab intersection test.
//
// The slave stream carries one ray and one box per beat, twelve signed
// Q16.16 coordinates. The master stream returns one beat per input beat
// holding the hit flag in bit 0 of m_tdata.
// The parallel epsilon register is written through cfg_wr_en/cfg_wr_data
// and must only change while no beat is in flight.
// From an accepted input beat to the result beat, 35 stages form the
// reciprocals, one quotient bit per stage for 33 bits, and 7 stages
// form the slab distances and the hit decision.
// Beats flow one per cycle while m_tready is high. Every stage has its own
// valid bit and loads whenever it is empty or its successor moves, so
// bubbles close up and input beats keep flowing while a result waits at
// the output. When the receiver stalls, the pipeline fills and s_tready
// drops only once every stage holds a beat; nothing is lost or repeated.
// Reset clears all valid bits and sets the epsilon register to 7.
`timescale 1ns / 1ps
module ray_box_slab_test_core import rbst_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [EPS_BITS-1:0]     cfg_wr_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // origin_x/y/z, direction_x/y/z, box_low_x/y/z, box_high_x/y/z
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // hit, then zero fill
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    logic [EPS_BITS-1:0]   eps_reg;
    geom_t                 geom;
    coord_t [NUM_AXES-1:0] dir;
    logic                  mid_valid;
    logic                  mid_ready;
    recip_out_t            mid_data;
    logic                  hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_wr_en) begin
            eps_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            geom.origin[a] = s_tdata[a*COORD_BITS +: COORD_BITS];
            dir[a]         = s_tdata[(NUM_AXES+a)*COORD_BITS +: COORD_BITS];
            geom.low[a]    = s_tdata[(2*NUM_AXES+a)*COORD_BITS +: COORD_BITS];
            geom.high[a]   = s_tdata[(3*NUM_AXES+a)*COORD_BITS +: COORD_BITS];
        end
    end

    rbst_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eps       (eps_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_geom   (geom),
        .in_dir    (dir),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    rbst_slab u_slab (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit)
    );

    assign m_tdata = {{(M_TDATA_BITS-1){1'b0}}, hit};

endmodule

>>> rtl/rbst_recip.sv
// Pipelined reciprocal of the three direction components, one quotient bit per stage.
`timescale 1ns / 1ps
module rbst_recip import rbst_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [EPS_BITS-1:0] eps,
    input  logic                in_valid,
    output logic                in_ready,
    input  geom_t               in_geom,
    input  coord_t [NUM_AXES-1:0] in_dir,
    output logic                out_valid,
    input  logic                out_ready,
    output recip_out_t          out_data
);

    localparam int NS = QUOT_BITS + 2;

    typedef struct packed {
        geom_t                              geom;
        logic [NUM_AXES-1:0]                par;
        logic [NUM_AXES-1:0]                neg;
        umag_t [NUM_AXES-1:0]               dmag;
        umag_t [NUM_AXES-1:0]               rem;
        logic [NUM_AXES-1:0][QUOT_BITS-1:0] quo;
    } div_st_t;

    div_st_t         st_reg  [QUOT_BITS+1];
    div_st_t         st_next [QUOT_BITS+1];
    recip_out_t      out_reg;
    recip_out_t      out_next;
    logic [NS-1:0]   v_reg;
    logic [NS:0]     ld;
    logic [COORD_BITS:0] sh;
    logic            ge;
    logic [QUOT_BITS-1:0] q;

    always_comb begin
        ld[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_comb begin
        sh = '0;
        ge = 1'b0;
        q  = '0;
        st_next[0].geom = in_geom;
        for (int a = 0; a < NUM_AXES; a++) begin
            st_next[0].neg[a]  = in_dir[a][COORD_BITS-1];
            st_next[0].dmag[a] = in_dir[a][COORD_BITS-1] ? umag_t'(-in_dir[a])
                                                         : umag_t'(in_dir[a]);
            st_next[0].par[a]  = st_next[0].dmag[a] <= umag_t'(eps);
            st_next[0].rem[a]  = '0;
            st_next[0].quo[a]  = '0;
        end
        for (int k = 1; k <= QUOT_BITS; k++) begin
            st_next[k] = st_reg[k-1];
            for (int a = 0; a < NUM_AXES; a++) begin
                sh = {st_reg[k-1].rem[a], 1'(k == 1)};
                ge = sh >= {1'b0, st_reg[k-1].dmag[a]};
                st_next[k].rem[a] = ge ? umag_t'(sh - {1'b0, st_reg[k-1].dmag[a]})
                                       : sh[COORD_BITS-1:0];
                st_next[k].quo[a] = {st_reg[k-1].quo[a][QUOT_BITS-2:0], ge};
            end
        end
        out_next.geom = st_reg[QUOT_BITS].geom;
        for (int a = 0; a < NUM_AXES; a++) begin
            q = st_reg[QUOT_BITS].quo[a];
            if (st_reg[QUOT_BITS].par[a]) begin
                out_next.inv[a].mag = MAX_MAG;
                out_next.inv[a].neg = 1'b0;
            end else begin
                out_next.inv[a].mag = (|q[QUOT_BITS-1:MAG_BITS]) ? MAX_MAG
                                                                 : q[MAG_BITS-1:0];
                out_next.inv[a].neg = st_reg[QUOT_BITS].neg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= QUOT_BITS; k++) begin
            if (ld[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (ld[NS-1]) begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

endmodule

>>> rtl/rbst_slab.sv
// Slab distances, per-axis ordering and the final near/far hit decision.
`timescale 1ns / 1ps
module rbst_slab import rbst_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  recip_out_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_hit
);

    localparam int NS = 7;

    typedef struct packed {
        logic  [NUM_AXES-1:0][1:0] sgn;
        umag_t [NUM_AXES-1:0][1:0] dmag;
        mag_t  [NUM_AXES-1:0]      imag;
    } s1_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][1:0]                sgn;
        logic [NUM_AXES-1:0][1:0][PROD_BITS-1:0] plo;
        logic [NUM_AXES-1:0][1:0][PROD_BITS-1:0] phi;
    } s2_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][1:0]               sgn;
        logic [NUM_AXES-1:0][1:0][SUM_BITS-1:0] r;
    } s3_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    coord_t [NUM_AXES-1:0][1:0] s4_reg, s4_next;
    coord_t [NUM_AXES-1:0] tmn_reg, tmn_next, tmx_reg, tmx_next;
    coord_t near_reg, near_next, far_reg, far_next;
    logic   hit_reg, hit_next;

    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;
    logic [COORD_BITS:0] diff;
    logic [COORD_BITS:0] dm;
    coord_t corner;
    mag_t   tm;

    always_comb begin
        ld[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_comb begin
        diff   = '0;
        dm     = '0;
        corner = '0;
        tm     = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            s1_next.imag[a] = in_data.inv[a].mag;
            for (int c = 0; c < 2; c++) begin
                corner = (c == 0) ? in_data.geom.low[a] : in_data.geom.high[a];
                diff = {corner[COORD_BITS-1], corner}
                     - {in_data.geom.origin[a][COORD_BITS-1], in_data.geom.origin[a]};
                dm = diff[COORD_BITS] ? -diff : diff;
                s1_next.dmag[a][c] = dm[COORD_BITS-1:0];
                s1_next.sgn[a][c]  = diff[COORD_BITS] ^ in_data.inv[a].neg;

                s2_next.sgn[a][c] = s1_reg.sgn[a][c];
                s2_next.plo[a][c] = PROD_BITS'(s1_reg.dmag[a][c][SPLIT_BITS-1:0])
                                  * PROD_BITS'(s1_reg.imag[a]);
                s2_next.phi[a][c] = PROD_BITS'(s1_reg.dmag[a][c][COORD_BITS-1:SPLIT_BITS])
                                  * PROD_BITS'(s1_reg.imag[a]);

                s3_next.sgn[a][c] = s2_reg.sgn[a][c];
                s3_next.r[a][c]   = SUM_BITS'(s2_reg.phi[a][c])
                                  + SUM_BITS'(s2_reg.plo[a][c] >> FRAC_BITS);

                tm = (|s3_reg.r[a][c][SUM_BITS-1:MAG_BITS]) ? MAX_MAG
                                                            : s3_reg.r[a][c][MAG_BITS-1:0];
                s4_next[a][c] = s3_reg.sgn[a][c] ? coord_t'(-{1'b0, tm})
                                                 : coord_t'({1'b0, tm});
            end
            if ($signed(s4_reg[a][0]) < $signed(s4_reg[a][1])) begin
                tmn_next[a] = s4_reg[a][0];
                tmx_next[a] = s4_reg[a][1];
            end else begin
                tmn_next[a] = s4_reg[a][1];
                tmx_next[a] = s4_reg[a][0];
            end
        end
        near_next = tmn_reg[0];
        far_next  = tmx_reg[0];
        for (int a = 1; a < NUM_AXES; a++) begin
            if ($signed(tmn_reg[a]) > $signed(near_next)) begin
                near_next = tmn_reg[a];
            end
            if ($signed(tmx_reg[a]) < $signed(far_next)) begin
                far_next = tmx_reg[a];
            end
        end
        hit_next = ($signed(near_reg) <= $signed(far_reg)) && !far_reg[COORD_BITS-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            s1_reg <= s1_next;
        end
        if (ld[1]) begin
            s2_reg <= s2_next;
        end
        if (ld[2]) begin
            s3_reg <= s3_next;
        end
        if (ld[3]) begin
            s4_reg <= s4_next;
        end
        if (ld[4]) begin
            tmn_reg <= tmn_next;
            tmx_reg <= tmx_next;
        end
        if (ld[5]) begin
            near_reg <= near_next;
            far_reg  <= far_next;
        end
        if (ld[6]) begin
            hit_reg <= hit_next;
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NS-1];
    assign out_hit   = hit_reg;

endmodule
